// ----- design/column_top_k_selector_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef COLUMN_TOP_K_SELECTOR_UNIT_DEFINES_SVH
`define COLUMN_TOP_K_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTSK_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctsk assertion failed");

// Next-cycle implication, disabled during reset.
`define CTSK_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctsk assertion failed");

`endif

// ----- design/ctsk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ctsk_pkg;

    localparam int TOP_K       = 4;
    localparam int MAX_ROWS    = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int ROW_W       = 5;
    localparam int RANK_W      = 2;
    localparam int ROWCNT_W    = $clog2(MAX_ROWS + 1);
    localparam int DRAIN_W     = $clog2(TOP_K + 1);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_value;
        logic                   column_end;
    } sample_t;

    typedef struct packed {
        logic [RANK_W-1:0]      rank_position;
        logic [ROW_W-1:0]       row_index;
        logic [SAMPLE_BITS-1:0] ranked_value;
        logic                   entry_valid;
        logic                   final_result;
    } result_t;

    // Broadcast from the control logic to every cell.
    typedef struct packed {
        logic                   insert;
        logic                   load;
        logic                   shift;
        logic [SAMPLE_BITS-1:0] value;
        logic [ROW_W-1:0]       row;
    } ctrl_t;

    // Insert chain: a cell tells its lower-ranked neighbor its content and
    // whether the new sample lands at or above it.
    typedef struct packed {
        logic                   here;
        logic                   valid;
        logic [SAMPLE_BITS-1:0] value;
        logic [ROW_W-1:0]       row;
    } link_t;

    // Drain chain entry, shifts toward rank 0.
    typedef struct packed {
        logic                   valid;
        logic [SAMPLE_BITS-1:0] value;
        logic [ROW_W-1:0]       row;
    } slot_t;

endpackage

`default_nettype wire

// ----- design/ctsk_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ctsk_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctsk_pkg::ctrl_t  ctrl,
    input  wire ctsk_pkg::link_t  link_in,
    output ctsk_pkg::link_t       link_out,
    input  wire ctsk_pkg::slot_t  slot_in,
    output ctsk_pkg::slot_t       slot
);

    logic                             valid_reg, valid_next;
    logic [ctsk_pkg::SAMPLE_BITS-1:0] value_reg, value_next;
    logic [ctsk_pkg::ROW_W-1:0]       row_reg, row_next;
    ctsk_pkg::slot_t                  slot_reg, slot_next;
    logic                             here;
    logic                             kv;

    // Ties rank below the kept entry, so only a strictly larger sample, or any sample at an empty cell, lands here.
    assign here = !valid_reg || (ctrl.value > value_reg);

    assign link_out.here  = here;
    assign link_out.valid = valid_reg;
    assign link_out.value = value_reg;
    assign link_out.row   = row_reg;

    always_comb
    begin
        kv         = valid_reg;
        value_next = value_reg;
        row_next   = row_reg;
        if (ctrl.insert)
        begin
            if (link_in.here)
            begin
                kv         = link_in.valid;
                value_next = link_in.value;
                row_next   = link_in.row;
            end
            else if (here)
            begin
                kv         = 1'b1;
                value_next = ctrl.value;
                row_next   = ctrl.row;
            end
        end
        valid_next = ctrl.load ? 1'b0 : kv;

        slot_next = slot_reg;
        if (ctrl.load)
        begin
            slot_next.valid = kv;
            slot_next.value = kv ? value_next : '0;
            slot_next.row   = kv ? row_next : '0;
        end
        else if (ctrl.shift)
        begin
            slot_next = slot_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        row_reg   <= row_next;
        slot_reg  <= slot_next;
    end

    assign slot = slot_reg;

endmodule

`default_nettype wire

// ----- design/column_top_k_selector_unit.sv -----
// Column top-K selector.
// Input channel (sample_valid / sample_stall / sample): one sample per transfer,
// column_end set on the last sample of a column. A sample that is not stalled
// is taken every cycle; each is inserted into a row of TOP_K sorted cells in
// the cycle it arrives. Zero samples and samples past MAX_ROWS are dropped.
// Output channel (result_valid / result_stall / result): on the column-end
// transfer the sorted list is copied to a drain chain, and TOP_K results follow,
// rank 0 first, starting the next cycle, one per cycle while not stalled.
// The last one carries final_result. Slots never filled give entry_valid = 0
// with zero row and value.
// The next column's samples stream in while results drain. A column-end
// sample is held off (sample_stall high) until the earlier column's last
// result transfers; it may be taken in that same cycle, so one column per
// TOP_K results at most is the limit set by the single output port.
// A stalled result holds its value. Reset empties the cells and clears the
// drain count; no results are pending after reset.
`timescale 1ns / 1ps
`default_nettype none

module column_top_k_selector_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire ctsk_pkg::sample_t  sample,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output ctsk_pkg::result_t       result
);

    logic [ctsk_pkg::ROWCNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [ctsk_pkg::DRAIN_W-1:0]  drain_cnt_reg, drain_cnt_next;
    logic                          in_xfer;
    logic                          out_xfer;
    logic                          row_open;
    logic                          drain_busy;
    ctsk_pkg::ctrl_t               ctrl;
    ctsk_pkg::link_t               link [ctsk_pkg::TOP_K+1];
    ctsk_pkg::slot_t               slot [ctsk_pkg::TOP_K+1];

    assign result_valid = (drain_cnt_reg != '0);
    assign out_xfer     = result_valid && !result_stall;
    // The drain chain may be reloaded in the cycle its last result leaves.
    assign drain_busy   = result_valid &&
                          !((drain_cnt_reg == ctsk_pkg::DRAIN_W'(1)) && out_xfer);
    assign sample_stall = sample.column_end && drain_busy;
    assign in_xfer      = sample_valid && !sample_stall;
    assign row_open     = (row_cnt_reg < ctsk_pkg::ROWCNT_W'(ctsk_pkg::MAX_ROWS));

    assign ctrl.insert = in_xfer && row_open && (sample.sample_value != '0);
    assign ctrl.load   = in_xfer && sample.column_end;
    assign ctrl.shift  = out_xfer;
    assign ctrl.value  = sample.sample_value;
    assign ctrl.row    = ctsk_pkg::ROW_W'(row_cnt_reg);

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        if (ctrl.load)
        begin
            row_cnt_next = '0;
        end
        else if (in_xfer && row_open)
        begin
            row_cnt_next = row_cnt_reg + ctsk_pkg::ROWCNT_W'(1);
        end

        drain_cnt_next = drain_cnt_reg;
        if (ctrl.load)
        begin
            drain_cnt_next = ctsk_pkg::DRAIN_W'(ctsk_pkg::TOP_K);
        end
        else if (out_xfer)
        begin
            drain_cnt_next = drain_cnt_reg - ctsk_pkg::DRAIN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            drain_cnt_reg <= '0;
        end
        else
        begin
            row_cnt_reg   <= row_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    assign link[0]              = '0;
    assign slot[ctsk_pkg::TOP_K] = '0;

    for (genvar i = 0; i < ctsk_pkg::TOP_K; i++)
    begin : g_cell
        ctsk_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .slot_in  (slot[i+1]),
            .slot     (slot[i])
        );
    end

    assign result.rank_position = ctsk_pkg::RANK_W'(ctsk_pkg::TOP_K - int'(drain_cnt_reg));
    assign result.row_index     = slot[0].row;
    assign result.ranked_value  = slot[0].value;
    assign result.entry_valid   = slot[0].valid;
    assign result.final_result  = (drain_cnt_reg == ctsk_pkg::DRAIN_W'(1));

endmodule

`default_nettype wire

// ----- design/ctsk_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "column_top_k_selector_unit_defines.svh"

module ctsk_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              sample_valid,
    input wire logic              sample_stall,
    input wire ctsk_pkg::sample_t sample,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire ctsk_pkg::result_t result
);

    logic [ctsk_pkg::RANK_W-1:0] last_rank;
    logic [ctsk_pkg::RANK_W-1:0] rank_cur;
    logic [ctsk_pkg::RANK_W-1:0] rank_inc;
    logic                        out_xfer;
    logic                        out_hold;
    logic                        empty_slot;
    logic                        blank;
    logic                        mid_xfer;

    assign last_rank  = ctsk_pkg::RANK_W'(ctsk_pkg::TOP_K - 1);
    assign rank_cur   = result.rank_position;
    assign rank_inc   = rank_cur + ctsk_pkg::RANK_W'(1);
    assign out_xfer   = result_valid && !result_stall;
    assign out_hold   = result_valid && result_stall;
    assign empty_slot = result_valid && !result.entry_valid;
    assign blank      = (result.row_index == '0) && (result.ranked_value == '0);
    assign mid_xfer   = out_xfer && !result.final_result;

    `CTSK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, result_valid && $stable(result))
    `CTSK_ASSERT_NOW(a_invalid_zero, clk, rst_n, empty_slot, blank)
    `CTSK_ASSERT_NOW(a_final_rank, clk, rst_n, result_valid && result.final_result, rank_cur == last_rank)
    `CTSK_ASSERT_NEXT(a_burst_cont, clk, rst_n, mid_xfer, result_valid && rank_cur == $past(rank_inc))
    `CTSK_ASSERT_NOW(a_end_stall, clk, rst_n, sample_stall, sample_valid ? sample.column_end : 1'b1)

endmodule

bind column_top_k_selector_unit ctsk_checker u_ctsk_checker (.*);

`default_nettype wire
